// ----- design/msq_pkg.sv -----
// Shared types, constants and lookup functions for the marching squares cell segment block.
package msq_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAG_W      = VALUE_BITS;
  localparam int DEN_W      = MAG_W + 1;
  localparam int SIZE_W     = 7;
  localparam int REM_W      = DEN_W + SIZE_W - 1;
  localparam int PIX_W      = 12;
  localparam int ROWS_W     = 11;
  localparam int ROW_IDX_W  = 10;
  localparam int LW_W       = 4;
  localparam int ROW_LIMIT  = 1024;
  localparam int DIV_STEPS  = SIZE_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int IN_DATA_W  = 4 * VALUE_BITS;
  localparam int SEG_BITS   = 4 * PIX_W + LW_W;
  localparam int OUT_DATA_W = ((SEG_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - SEG_BITS;

  localparam logic [SIZE_W-1:0]     CELL_SIZE_RST = SIZE_W'(16);
  localparam logic [ROWS_W-1:0]     ROWS_RST      = ROWS_W'(116);
  localparam logic [PIX_W-1:0]      TOP_RST       = '0;
  localparam logic [LW_W-1:0]       LINE_W_RST    = LW_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL_SIZE,
    CFG_ROWS,
    CFG_TOP,
    CFG_LINE_WIDTH,
    CFG_INTERP
  } cfg_idx_t;

  // corner slots in the capture registers
  typedef enum logic [1:0] {C_TL, C_TR, C_BR, C_BL} corner_t;

  // crossing points, one per cell edge: left, bottom, right, top
  typedef enum logic [1:0] {PT_L, PT_B, PT_R, PT_T} pt_t;

  typedef struct packed {
    pt_t        p0s;
    pt_t        p0e;
    pt_t        p1s;
    pt_t        p1e;
    logic [1:0] n;
  } seg_plan_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT0,
    ST_EMIT1
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic emit;
    logic emit_sel;
    logic emit_last;
    logic advance;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] n_seg;
    logic       out_free;
  } dp_status_t;

  function automatic logic [MAG_W-1:0] mag(input logic [VALUE_BITS-1:0] raw);
    logic [MAG_W-1:0] m;
    m = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
    return m;
  endfunction

  function automatic seg_plan_t seg_plan(input logic [3:0] ms);
    seg_plan_t p;
    p = '{p0s: PT_L, p0e: PT_L, p1s: PT_L, p1e: PT_L, n: 2'd0};
    case (ms)
      4'd1, 4'd14: begin p.p0s = PT_L; p.p0e = PT_B; p.n = 2'd1; end
      4'd2, 4'd13: begin p.p0s = PT_B; p.p0e = PT_R; p.n = 2'd1; end
      4'd3, 4'd12: begin p.p0s = PT_L; p.p0e = PT_R; p.n = 2'd1; end
      4'd4, 4'd11: begin p.p0s = PT_T; p.p0e = PT_R; p.n = 2'd1; end
      4'd5: begin
        p.p0s = PT_B; p.p0e = PT_R; p.p1s = PT_L; p.p1e = PT_T; p.n = 2'd2;
      end
      4'd6, 4'd9:  begin p.p0s = PT_T; p.p0e = PT_B; p.n = 2'd1; end
      4'd7, 4'd8:  begin p.p0s = PT_L; p.p0e = PT_T; p.n = 2'd1; end
      4'd10: begin
        p.p0s = PT_T; p.p0e = PT_R; p.p1s = PT_L; p.p1e = PT_B; p.n = 2'd2;
      end
      default: p.n = 2'd0;
    endcase
    return p;
  endfunction

endpackage

// ----- design/msq_ctrl.sv -----
// Controller state machine: sequences capture, multiply, division steps and segment requests.
module msq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  msq_pkg::dp_status_t   status,
  output msq_pkg::ctrl_cmd_t    cmd
);

  msq_pkg::state_t              state_r, state_nxt;
  logic [msq_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msq_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      msq_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = msq_pkg::ST_MUL;
        end
      end
      msq_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = msq_pkg::ST_DIV;
      end
      msq_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = msq_pkg::CNT_W'(cnt_r + 1'b1);
        if (cnt_r == msq_pkg::CNT_W'(msq_pkg::DIV_STEPS - 1)) begin
          state_nxt = msq_pkg::ST_EMIT0;
        end
      end
      msq_pkg::ST_EMIT0: begin
        if (status.n_seg == 2'd0) begin
          cmd.advance = 1'b1;
          state_nxt   = msq_pkg::ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = 1'b0;
          cmd.emit_last = (status.n_seg == 2'd1);
          if (status.n_seg == 2'd1) begin
            cmd.advance = 1'b1;
            state_nxt   = msq_pkg::ST_IDLE;
          end else begin
            state_nxt = msq_pkg::ST_EMIT1;
          end
        end
      end
      msq_pkg::ST_EMIT1: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.advance   = 1'b1;
          state_nxt     = msq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = msq_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- design/msq_dp.sv -----
// Datapath: config registers, scan position, a divider for each cell edge, segment output register.
module msq_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [msq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [msq_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [msq_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tuser,
  output logic [msq_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  msq_pkg::ctrl_cmd_t                cmd,
  output msq_pkg::dp_status_t               status
);

  localparam int VB = msq_pkg::VALUE_BITS;
  localparam int PW = msq_pkg::PIX_W;
  localparam int SW = msq_pkg::SIZE_W;

  logic [SW-1:0]                 cell_size_r;
  logic [msq_pkg::ROWS_W-1:0]    rows_r;
  logic [PW-1:0]                 top_r;
  logic [msq_pkg::LW_W-1:0]      line_w_r;
  logic                          interp_r;

  logic [PW-1:0]                 col_px_r, row_px_r;
  logic [msq_pkg::ROW_IDX_W-1:0] row_idx_r;
  logic [msq_pkg::ROWS_W-1:0]    row_next;

  logic [3:0]                    ms_r;
  logic [msq_pkg::MAG_W-1:0]     mag_r [4];
  logic [msq_pkg::REM_W-1:0]     rem_r [4];
  logic [msq_pkg::REM_W-1:0]     dsh_r [4];
  logic [SW-1:0]                 q_r   [4];
  logic [3:0]                    dz_r;

  logic [msq_pkg::MAG_W-1:0]     a_sel [4];
  logic [msq_pkg::MAG_W-1:0]     b_sel [4];
  logic [SW-1:0]                 off   [4];
  logic [PW-1:0]                 px    [4];
  logic [PW-1:0]                 py    [4];

  msq_pkg::seg_plan_t            plan;
  msq_pkg::pt_t                  ps, pe;

  logic [msq_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic                           out_tlast_r, out_tvalid_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r <= msq_pkg::CELL_SIZE_RST;
      rows_r      <= msq_pkg::ROWS_RST;
      top_r       <= msq_pkg::TOP_RST;
      line_w_r    <= msq_pkg::LINE_W_RST;
      interp_r    <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        msq_pkg::CFG_CELL_SIZE:  cell_size_r <= cfg_data[SW-1:0];
        msq_pkg::CFG_ROWS:       rows_r      <= cfg_data[msq_pkg::ROWS_W-1:0];
        msq_pkg::CFG_TOP:        top_r       <= cfg_data[PW-1:0];
        msq_pkg::CFG_LINE_WIDTH: line_w_r    <= cfg_data[msq_pkg::LW_W-1:0];
        msq_pkg::CFG_INTERP:     interp_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // scan position
  assign row_next = msq_pkg::ROWS_W'(row_idx_r) + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_px_r  <= '0;
      row_px_r  <= msq_pkg::TOP_RST;
      row_idx_r <= '0;
    end else if (cmd.load && in_tuser) begin
      col_px_r  <= '0;
      row_px_r  <= top_r;
      row_idx_r <= '0;
    end else if (cmd.advance) begin
      if (row_next >= rows_r || row_next >= msq_pkg::ROWS_W'(msq_pkg::ROW_LIMIT)) begin
        row_idx_r <= '0;
        row_px_r  <= top_r;
        col_px_r  <= col_px_r + PW'(cell_size_r);
      end else begin
        row_idx_r <= row_next[msq_pkg::ROW_IDX_W-1:0];
        row_px_r  <= row_px_r + PW'(cell_size_r);
      end
    end
  end

  // edge order: left (tl,bl), bottom (bl,br), right (tr,br), top (tl,tr)
  always_comb begin
    a_sel[msq_pkg::PT_L] = mag_r[msq_pkg::C_TL];
    b_sel[msq_pkg::PT_L] = mag_r[msq_pkg::C_BL];
    a_sel[msq_pkg::PT_B] = mag_r[msq_pkg::C_BL];
    b_sel[msq_pkg::PT_B] = mag_r[msq_pkg::C_BR];
    a_sel[msq_pkg::PT_R] = mag_r[msq_pkg::C_TR];
    b_sel[msq_pkg::PT_R] = mag_r[msq_pkg::C_BR];
    a_sel[msq_pkg::PT_T] = mag_r[msq_pkg::C_TL];
    b_sel[msq_pkg::PT_T] = mag_r[msq_pkg::C_TR];
  end

  // capture, multiply, then restoring division one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int c = 0; c < 4; c++) begin
        mag_r[c] <= msq_pkg::mag(in_tdata[c*VB +: VB]);
      end
      ms_r <= {~in_tdata[1*VB-1], ~in_tdata[2*VB-1], ~in_tdata[3*VB-1], ~in_tdata[4*VB-1]};
    end
    if (cmd.mul) begin
      for (int e = 0; e < 4; e++) begin
        rem_r[e] <= msq_pkg::REM_W'(cell_size_r) * msq_pkg::REM_W'(a_sel[e]);
        dsh_r[e] <= (msq_pkg::REM_W'(a_sel[e]) + msq_pkg::REM_W'(b_sel[e])) << (SW - 1);
        dz_r[e]  <= (a_sel[e] == '0) && (b_sel[e] == '0);
        q_r[e]   <= '0;
      end
    end else if (cmd.step) begin
      for (int e = 0; e < 4; e++) begin
        if (rem_r[e] >= dsh_r[e]) begin
          rem_r[e] <= rem_r[e] - dsh_r[e];
          q_r[e]   <= {q_r[e][SW-2:0], 1'b1};
        end else begin
          q_r[e]   <= {q_r[e][SW-2:0], 1'b0};
        end
        dsh_r[e] <= dsh_r[e] >> 1;
      end
    end
  end

  // crossing points
  always_comb begin
    for (int e = 0; e < 4; e++) begin
      if (!interp_r) begin
        off[e] = cell_size_r >> 1;
      end else if (dz_r[e]) begin
        off[e] = '0;
      end else begin
        off[e] = q_r[e];
      end
    end
    px[msq_pkg::PT_L] = col_px_r;
    py[msq_pkg::PT_L] = row_px_r + PW'(off[msq_pkg::PT_L]);
    px[msq_pkg::PT_B] = col_px_r + PW'(off[msq_pkg::PT_B]);
    py[msq_pkg::PT_B] = row_px_r + PW'(cell_size_r);
    px[msq_pkg::PT_R] = col_px_r + PW'(cell_size_r);
    py[msq_pkg::PT_R] = row_px_r + PW'(off[msq_pkg::PT_R]);
    px[msq_pkg::PT_T] = col_px_r + PW'(off[msq_pkg::PT_T]);
    py[msq_pkg::PT_T] = row_px_r;
  end

  assign plan = msq_pkg::seg_plan(ms_r);
  assign ps   = cmd.emit_sel ? plan.p1s : plan.p0s;
  assign pe   = cmd.emit_sel ? plan.p1e : plan.p0e;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_tdata_r <= {{msq_pkg::OUT_PAD_W{1'b0}}, line_w_r, py[pe], px[pe], py[ps], px[ps]};
      out_tlast_r <= cmd.emit_last;
    end
  end

  assign out_tdata       = out_tdata_r;
  assign out_tlast       = out_tlast_r;
  assign out_tvalid      = out_tvalid_r;
  assign status.n_seg    = plan.n;
  assign status.out_free = !out_tvalid_r || out_tready;

endmodule

// ----- design/marching_squares_cell_segments.sv -----
// Top level of the marching squares cell segment generator.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tdata: four corners, tuser: frame_start
//  out_    | out | out_tvalid/out_tready| tdata: segment + stroke, tlast: last_segment
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A cell passes through capture, a multiply, then 7 restoring-division steps shared
// by the dividers of every cell edge, then a segment request for each segment into the output
// register.
// Reset is synchronous, active low; no clearing pass. A stalled output holds the
// segment machine; input is taken only while no cell is in progress.
module marching_squares_cell_segments (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: corner_top_left, corner_top_right, corner_bottom_right, corner_bottom_left
  input  logic [msq_pkg::IN_DATA_W-1:0]     in_tdata,
  // tuser: frame_start
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: seg_x_start, seg_y_start, seg_x_end, seg_y_end, stroke_width, zero pad
  output logic [msq_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [msq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [msq_pkg::CFG_DATA_W-1:0]    cfg_data
);

  msq_pkg::ctrl_cmd_t  cmd;
  msq_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  msq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  msq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

// ----- design/msq_chk.sv -----
// Port-level checker for the marching squares cell segment block, bound to the top level.
module msq_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [msq_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tlast
);

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  a_one_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a cell is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled output request changed");

  a_second_seg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> out_tvalid)
    else $error("second segment of a cell missing");

endmodule

bind marching_squares_cell_segments msq_chk u_msq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ----- tb/marching_squares_cell_segments_tb.sv -----
// Self-checking testbench for the marching squares cell segment generator.
module marching_squares_cell_segments_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] VMIN = 32'h8000_0000;
  localparam logic [31:0] VMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] M1   = 32'hFFFF_FFFF;
  localparam logic [31:0] POS  = 32'h0001_8000;
  localparam logic [31:0] NEG  = 32'hFFFF_C000;
  localparam logic [msq_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam int DIR_N = 21;

  typedef struct packed {
    logic [11:0] xs;
    logic [11:0] ys;
    logic [11:0] xe;
    logic [11:0] ye;
    logic [3:0]  stroke;
    logic        tail;
  } seg_t;

  // tl, tr, br, bl, frame_start, typed, typed count, xs, ys, xe, ye, stroke
  typedef struct packed {
    logic [31:0] tl;
    logic [31:0] tr;
    logic [31:0] br;
    logic [31:0] bl;
    logic        fs;
    logic        typed;
    logic [1:0]  n;
    logic [11:0] xs;
    logic [11:0] ys;
    logic [11:0] xe;
    logic [11:0] ye;
    logic [3:0]  sw;
  } cell_row_t;

  // default config; typed rows with segments restart the scan so the origin is (0,0), cell 16
  localparam cell_row_t DIR_TBL [DIR_N] = '{
    '{M1,   M1,   M1,   M1,   1'b1, 1'b1, 2'd0, 12'd0, 12'd0,  12'd0, 12'd0,  4'd0},
    '{M1,   M1,   M1,   32'd0, 1'b1, 1'b1, 2'd1, 12'd0, 12'd16, 12'd0, 12'd16, 4'd2},
    '{VMIN, VMIN, VMIN, VMAX, 1'b1, 1'b1, 2'd1, 12'd0, 12'd8,  12'd7, 12'd16, 4'd2},
    '{32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1, 2'd0, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0},
    '{VMIN, VMAX, VMIN, VMAX, 1'b0, 1'b0, 2'd0, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0},
    '{VMAX, VMIN, VMAX, VMIN, 1'b0, 1'b0, 2'd0, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0},
    '{NEG,  NEG,  NEG,  POS,  1'b0, 1'b0, 2'd0, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0},
    '{NEG,  NEG,  POS,  NEG,  1'b0, 1'b0, 2'd0, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0},
    '{NEG,  NEG,  POS,  POS,  1'b0, 1'b0, 2'd0, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0},
    '{NEG,  POS,  NEG,  NEG,  1'b0, 1'b0, 2'd0, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0},
    '{NEG,  POS,  NEG,  POS,  1'b0, 1'b0, 2'd0, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0},
    '{NEG,  POS,  POS,  NEG,  1'b0, 1'b0, 2'd0, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0},
    '{NEG,  POS,  POS,  POS,  1'b0, 1'b0, 2'd0, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0},
    '{POS,  NEG,  NEG,  NEG,  1'b0, 1'b0, 2'd0, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0},
    '{POS,  NEG,  NEG,  POS,  1'b0, 1'b0, 2'd0, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0},
    '{POS,  NEG,  POS,  NEG,  1'b0, 1'b0, 2'd0, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0},
    '{POS,  NEG,  POS,  POS,  1'b1, 1'b0, 2'd0, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0},
    '{POS,  POS,  NEG,  NEG,  1'b0, 1'b0, 2'd0, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0},
    '{POS,  POS,  NEG,  POS,  1'b0, 1'b0, 2'd0, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0},
    '{POS,  POS,  POS,  NEG,  1'b0, 1'b0, 2'd0, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0},
    '{VMIN, 32'd0, 32'd1, M1, 1'b0, 1'b0, 2'd0, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [msq_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [msq_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [msq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [msq_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  marching_squares_cell_segments dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow configuration and scan position
  logic [6:0]  sz = 7'd16;
  logic [10:0] rows_cfg = 11'd116;
  logic [11:0] top_px = 12'd0;
  logic [3:0]  lw_cfg = 4'd2;
  logic        interp_on = 1'b1;
  logic [11:0] col_px = 12'd0;
  logic [11:0] row_px = 12'd0;
  int          row_cnt = 0;

  seg_t seg_expect_q[$];
  logic idle_on = 1'b1;
  int   fail_cnt = 0;
  int   cells_sent = 0;
  int   segs_seen = 0;
  int   cfg_writes = 0;
  int   quiet_cyc = 0;
  int   rdy_hold = 0;

  function automatic void add_expected(input seg_t s);
    seg_expect_q.insert(seg_expect_q.size(), s);
  endfunction

  function automatic logic [6:0] edge_offset(input logic [31:0] v1, input logic [31:0] v2);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] den;
    // 32-bit magnitudes never reach the pre-shift threshold
    a = v1[31] ? {32'd0, ~v1} + 64'd1 : {32'd0, v1};
    b = v2[31] ? {32'd0, ~v2} + 64'd1 : {32'd0, v2};
    if (!interp_on) return sz >> 1;
    den = a + b;
    if (den == 64'd0) return '0;
    return 7'((64'(sz) * a) / den);
  endfunction

  task automatic trace_cell(input logic [31:0] tl, input logic [31:0] tr,
                            input logic [31:0] br, input logic [31:0] bl,
                            input logic fs, output int n);
    logic [11:0]     px [0:3];
    logic [11:0]     py [0:3];
    logic [11:0]     x;
    logic [11:0]     y;
    logic [3:0]      ms;
    msq_pkg::pt_t    p0s, p0e, p1s, p1e, a, b;
    int              nxt;
    if (fs) begin
      col_px = '0;
      row_px = top_px;
      row_cnt = 0;
    end
    x = col_px;
    y = row_px;
    ms = {~tl[31], ~tr[31], ~br[31], ~bl[31]};
    px[msq_pkg::PT_L] = x;
    py[msq_pkg::PT_L] = y + 12'(edge_offset(tl, bl));
    px[msq_pkg::PT_B] = x + 12'(edge_offset(bl, br));
    py[msq_pkg::PT_B] = y + 12'(sz);
    px[msq_pkg::PT_R] = x + 12'(sz);
    py[msq_pkg::PT_R] = y + 12'(edge_offset(tr, br));
    px[msq_pkg::PT_T] = x + 12'(edge_offset(tl, tr));
    py[msq_pkg::PT_T] = y;
    p0s = msq_pkg::PT_L; p0e = msq_pkg::PT_L; p1s = msq_pkg::PT_L; p1e = msq_pkg::PT_L;
    n = 1;
    case (ms)
      4'd1, 4'd14: begin p0s = msq_pkg::PT_L; p0e = msq_pkg::PT_B; end
      4'd2, 4'd13: begin p0s = msq_pkg::PT_B; p0e = msq_pkg::PT_R; end
      4'd3, 4'd12: begin p0s = msq_pkg::PT_L; p0e = msq_pkg::PT_R; end
      4'd4, 4'd11: begin p0s = msq_pkg::PT_T; p0e = msq_pkg::PT_R; end
      4'd5: begin
        p0s = msq_pkg::PT_B; p0e = msq_pkg::PT_R;
        p1s = msq_pkg::PT_L; p1e = msq_pkg::PT_T; n = 2;
      end
      4'd6, 4'd9: begin p0s = msq_pkg::PT_T; p0e = msq_pkg::PT_B; end
      4'd7, 4'd8: begin p0s = msq_pkg::PT_L; p0e = msq_pkg::PT_T; end
      4'd10: begin
        p0s = msq_pkg::PT_T; p0e = msq_pkg::PT_R;
        p1s = msq_pkg::PT_L; p1e = msq_pkg::PT_B; n = 2;
      end
      default: n = 0;
    endcase
    for (int k = 0; k < n; k++) begin
      a = (k == 0) ? p0s : p1s;
      b = (k == 0) ? p0e : p1e;
      add_expected('{px[a], py[a], px[b], py[b], lw_cfg, k == n - 1});
    end
    nxt = row_cnt + 1;
    if (nxt >= int'(rows_cfg) || nxt >= msq_pkg::ROW_LIMIT) begin
      row_cnt = 0;
      row_px = top_px;
      col_px = col_px + 12'(sz);
    end else begin
      row_cnt = nxt;
      row_px = row_px + 12'(sz);
    end
  endtask

  task automatic send_cell(input logic [31:0] tl, input logic [31:0] tr,
                           input logic [31:0] br, input logic [31:0] bl,
                           input logic fs, output int n);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {bl, br, tr, tl};
    in_tuser <= fs;
    do @(posedge clk); while (!in_tready);
    trace_cell(tl, tr, br, bl, fs, n);
    cells_sent++;
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [msq_pkg::CFG_IDX_W-1:0] idx, input logic [11:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    case (idx)
      msq_pkg::CFG_CELL_SIZE:  sz = d[6:0];
      msq_pkg::CFG_ROWS:       rows_cfg = d[10:0];
      msq_pkg::CFG_TOP:        top_px = d[11:0];
      msq_pkg::CFG_LINE_WIDTH: lw_cfg = d[3:0];
      msq_pkg::CFG_INTERP:     interp_on = d[0];
      default: ;
    endcase
  endtask

  task automatic drain_results();
    while (seg_expect_q.size() != 0) @(posedge clk);
    // a cell with no segments may still be in flight
    repeat (20) @(posedge clk);
  endtask

  task automatic set_regs(input logic [11:0] size_v, input logic [11:0] rows_v,
                          input logic [11:0] top_v, input logic [11:0] lw_v,
                          input logic [11:0] interp_v);
    drain_results();
    write_reg(msq_pkg::CFG_CELL_SIZE, size_v);
    write_reg(msq_pkg::CFG_ROWS, rows_v);
    write_reg(msq_pkg::CFG_TOP, top_v);
    write_reg(msq_pkg::CFG_LINE_WIDTH, lw_v);
    write_reg(msq_pkg::CFG_INTERP, interp_v);
    write_reg(CFG_SPARE_IDX, 12'($urandom_range(0, 4095)));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_corner();
    logic [31:0] m;
    m = 32'($urandom_range(1, 1 << 20));
    case ($urandom_range(0, 9))
      0: return '0;
      1: return VMIN;
      2: return VMAX;
      3, 4: return $urandom();
      default: return $urandom_range(0, 1) ? -m : m;
    endcase
  endfunction

  task automatic run_phase(input int n_cells, input int fs_pct);
    int n;
    for (int k = 0; k < n_cells; k++)
      send_cell(rand_corner(), rand_corner(), rand_corner(), rand_corner(),
                k == 0 || $urandom_range(0, 99) < fs_pct, n);
    in_tvalid <= 1'b0;
  endtask

  task automatic report_seg(input string what, input seg_t want, input seg_t got);
    if (fail_cnt < 10) begin
      $write("%s: expected xs=%0d ys=%0d xe=%0d ye=%0d w=%0d last=%0d,",
             what, want.xs, want.ys, want.xe, want.ye, want.stroke, want.tail);
      $display(" got xs=%0d ys=%0d xe=%0d ye=%0d w=%0d last=%0d",
               got.xs, got.ys, got.xe, got.ye, got.stroke, got.tail);
    end
    fail_cnt++;
  endtask

  // output request stalls
  always @(posedge clk) begin
    if (rdy_hold > 0) begin
      rdy_hold = rdy_hold - 1;
      out_tready <= (rdy_hold == 0);
    end else if (idle_on && $urandom_range(0, 15) == 0) begin
      rdy_hold = $urandom_range(1, 13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : seg_check
    seg_t got;
    seg_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[11:0], out_tdata[23:12], out_tdata[35:24], out_tdata[47:36],
              out_tdata[51:48], out_tlast};
      segs_seen++;
      if (seg_expect_q.size() == 0) begin
        report_seg("unexpected segment", '0, got);
      end else begin
        want = seg_expect_q.pop_front();
        if (got !== want) report_seg("segment mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cyc <= 0;
      else
        quiet_cyc <= quiet_cyc + 1;
      if (quiet_cyc >= QUIET_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stim
    int n;
    cell_row_t r;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      r = DIR_TBL[i];
      send_cell(r.tl, r.tr, r.br, r.bl, r.fs, n);
      if (r.typed) begin
        repeat (n) void'(seg_expect_q.pop_back());
        if (r.n != 2'd0)
          add_expected('{r.xs, r.ys, r.xe, r.ye, r.sw, 1'b1});
      end
    end
    in_tvalid <= 1'b0;

    // extremes: big cells, one row per column, bottom origin, midpoints
    set_regs(12'd64, 12'd1, 12'd4095, 12'd15, 12'd0);
    run_phase(150, 5);
    set_regs(12'd1, 12'd1024, 12'd0, 12'd1, 12'd1);
    run_phase(150, 2);
    // degenerate values, no idling
    idle_on = 1'b0;
    set_regs(12'd0, 12'd0, 12'h800, 12'd0, 12'd1);
    run_phase(100, 2);
    idle_on = 1'b1;
    // long columns hit the row limit, coordinates wrap
    set_regs(12'd127, 12'd2047, 12'd4000, 12'd9, 12'd1);
    run_phase(1100, 0);
    set_regs(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
             12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
             12'($urandom_range(0, 4095)));
    run_phase(200, 3);
    idle_on = 1'b0;
    set_regs(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 40)),
             12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
             12'($urandom_range(0, 4095)));
    run_phase(150, 3);

    while (seg_expect_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    fail_cnt += seg_expect_q.size();

    $display("run covered %0d cells and %0d segments across %0d register writes",
             cells_sent, segs_seen, cfg_writes);
    $display("failures: %0d", fail_cnt);
    if (fail_cnt == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
